/* hw/rtl/apc_pkg.sv */
`timescale 1ns / 1ps

package apc_pkg;

   localparam int SYMBOL_BITS = 32;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ZERO_DIV = 2'd1,
      STATUS_OVERFLOW = 2'd2,
      STATUS_MISMATCH = 2'd3
   } status_type;

   // what rides along with a request through the divide chain
   typedef struct packed {
      logic [SYMBOL_BITS-1:0] symbol;
      status_type             status;
   } side_type;

endpackage

/* hw/rtl/apc_mul.sv */
`timescale 1ns / 1ps

module apc_mul #(
   parameter int AMOUNT_BITS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [AMOUNT_BITS-2:0]           in_asset_amount,
   input  logic [apc_pkg::SYMBOL_BITS-1:0]  in_asset_symbol,
   input  logic [AMOUNT_BITS-2:0]           in_base_amount,
   input  logic [apc_pkg::SYMBOL_BITS-1:0]  in_base_symbol,
   input  logic [AMOUNT_BITS-2:0]           in_quote_amount,
   input  logic [apc_pkg::SYMBOL_BITS-1:0]  in_quote_symbol,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [AMOUNT_BITS-2:0]           out_rem,
   output logic [AMOUNT_BITS-1:0]           out_work,
   output logic [AMOUNT_BITS-2:0]           out_divisor,
   output apc_pkg::side_type                out_side
);

   localparam int IN_BITS   = AMOUNT_BITS - 1;
   localparam int HALF_BITS = (IN_BITS + 1) / 2;
   localparam int PAD_BITS  = 2 * HALF_BITS;
   localparam int PROD_BITS = 2 * IN_BITS;

   // stage 1: operand select and partial products
   logic                     s1_valid_ff, s1_valid_in;
   logic [PAD_BITS-1:0]      ll_ff, lh_ff, hl_ff, hh_ff;
   logic [PAD_BITS-1:0]      ll_in, lh_in, hl_in, hh_in;
   logic [IN_BITS-1:0]       s1_div_ff, s1_div_in;
   apc_pkg::side_type        s1_side_ff, s1_side_in;
   logic [IN_BITS-1:0]       mult;
   logic [PAD_BITS-1:0]      amt_pad, mult_pad;
   logic                     s1_ready;

   // stage 2: product sum
   logic                     s2_valid_ff, s2_valid_in;
   logic [PROD_BITS-1:0]     prod_ff, prod_in;
   logic [IN_BITS-1:0]       s2_div_ff;
   apc_pkg::side_type        s2_side_ff;
   logic [PAD_BITS:0]        mid;
   logic [2*PAD_BITS-1:0]    prod_full;
   logic                     s2_ready;

   // stage 3: overflow check and divide setup
   logic                     s3_valid_ff, s3_valid_in;
   logic [IN_BITS-1:0]       rem_ff, rem_in;
   logic [AMOUNT_BITS-1:0]   work_ff;
   logic [IN_BITS-1:0]       s3_div_ff;
   apc_pkg::side_type        s3_side_ff, s3_side_in;
   logic [IN_BITS-1:0]       hi_ext;
   logic                     over;
   logic                     s3_ready;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      s1_side_in = '0;
      mult       = '0;
      s1_div_in  = '0;
      if (in_asset_symbol == in_base_symbol) begin
         mult              = in_quote_amount;
         s1_div_in         = in_base_amount;
         s1_side_in.symbol = in_quote_symbol;
      end else if (in_asset_symbol == in_quote_symbol) begin
         mult              = in_base_amount;
         s1_div_in         = in_quote_amount;
         s1_side_in.symbol = in_base_symbol;
      end
      if ((in_asset_symbol != in_base_symbol) && (in_asset_symbol != in_quote_symbol)) begin
         s1_side_in.status = apc_pkg::STATUS_MISMATCH;
      end else if (s1_div_in == '0) begin
         s1_side_in.status = apc_pkg::STATUS_ZERO_DIV;
      end else begin
         s1_side_in.status = apc_pkg::STATUS_OK;
      end
      amt_pad  = PAD_BITS'(in_asset_amount);
      mult_pad = PAD_BITS'(mult);
      ll_in = PAD_BITS'(amt_pad[HALF_BITS-1:0]) * PAD_BITS'(mult_pad[HALF_BITS-1:0]);
      lh_in = PAD_BITS'(amt_pad[HALF_BITS-1:0]) * PAD_BITS'(mult_pad[PAD_BITS-1:HALF_BITS]);
      hl_in = PAD_BITS'(amt_pad[PAD_BITS-1:HALF_BITS]) * PAD_BITS'(mult_pad[HALF_BITS-1:0]);
      hh_in = PAD_BITS'(amt_pad[PAD_BITS-1:HALF_BITS])
            * PAD_BITS'(mult_pad[PAD_BITS-1:HALF_BITS]);
      s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   end

   always_comb begin
      mid         = (PAD_BITS+1)'(lh_ff) + (PAD_BITS+1)'(hl_ff);
      prod_full   = {hh_ff, ll_ff} + ((2*PAD_BITS)'(mid) << HALF_BITS);
      prod_in     = prod_full[PROD_BITS-1:0];
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   end

   always_comb begin
      // quotient fits in AMOUNT_BITS exactly when the high product part is below the divisor
      hi_ext     = IN_BITS'(prod_ff[PROD_BITS-1:AMOUNT_BITS]);
      over       = (hi_ext >= s2_div_ff);
      s3_side_in = s2_side_ff;
      if (s2_side_ff.status == apc_pkg::STATUS_OK && over) begin
         s3_side_in.status = apc_pkg::STATUS_OVERFLOW;
      end
      rem_in      = (s3_side_in.status == apc_pkg::STATUS_OK) ? hi_ext : '0;
      s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && s1_ready) begin
         ll_ff      <= ll_in;
         lh_ff      <= lh_in;
         hl_ff      <= hl_in;
         hh_ff      <= hh_in;
         s1_div_ff  <= s1_div_in;
         s1_side_ff <= s1_side_in;
      end
      if (s1_valid_ff && s2_ready) begin
         prod_ff    <= prod_in;
         s2_div_ff  <= s1_div_ff;
         s2_side_ff <= s1_side_ff;
      end
      if (s2_valid_ff && s3_ready) begin
         rem_ff     <= rem_in;
         work_ff    <= prod_ff[AMOUNT_BITS-1:0];
         s3_div_ff  <= s2_div_ff;
         s3_side_ff <= s3_side_in;
      end
   end

   assign out_valid   = s3_valid_ff;
   assign out_rem     = rem_ff;
   assign out_work    = work_ff;
   assign out_divisor = s3_div_ff;
   assign out_side    = s3_side_ff;

endmodule

/* hw/rtl/apc_cell.sv */
`timescale 1ns / 1ps

module apc_cell #(
   parameter int AMOUNT_BITS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [AMOUNT_BITS-2:0]  in_rem,
   input  logic [AMOUNT_BITS-1:0]  in_work,
   input  logic [AMOUNT_BITS-2:0]  in_divisor,
   input  apc_pkg::side_type       in_side,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [AMOUNT_BITS-2:0]  out_rem,
   output logic [AMOUNT_BITS-1:0]  out_work,
   output logic [AMOUNT_BITS-2:0]  out_divisor,
   output apc_pkg::side_type       out_side
);

   localparam int IN_BITS = AMOUNT_BITS - 1;

   logic                    valid_ff, valid_in;
   logic [IN_BITS-1:0]      rem_ff, rem_in;
   logic [AMOUNT_BITS-1:0]  work_ff, work_in;
   logic [IN_BITS-1:0]      divisor_ff;
   apc_pkg::side_type       side_ff;
   logic [AMOUNT_BITS-1:0]  rem_sh, diff;
   logic                    ge;

   assign in_ready = !valid_ff || out_ready;

   // one restoring step: dividend bit out at the top of work, quotient bit in at the bottom
   always_comb begin
      rem_sh   = {in_rem, in_work[AMOUNT_BITS-1]};
      ge       = (rem_sh >= AMOUNT_BITS'(in_divisor));
      diff     = rem_sh - AMOUNT_BITS'(in_divisor);
      rem_in   = ge ? diff[IN_BITS-1:0] : rem_sh[IN_BITS-1:0];
      work_in  = {in_work[AMOUNT_BITS-2:0], ge};
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         rem_ff     <= rem_in;
         work_ff    <= work_in;
         divisor_ff <= in_divisor;
         side_ff    <= in_side;
      end
   end

   assign out_valid   = valid_ff;
   assign out_rem     = rem_ff;
   assign out_work    = work_ff;
   assign out_divisor = divisor_ff;
   assign out_side    = side_ff;

`ifndef SYNTHESIS
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && side_ff.status == apc_pkg::STATUS_OK) |-> (rem_ff < divisor_ff))
      else $error("partial remainder not below divisor");
`endif

endmodule

/* hw/rtl/asset_price_conversion.sv */
`timescale 1ns / 1ps

// Converts an asset amount through a base/quote price: amount * quote / base when the asset
// symbol matches the base symbol (result carries the quote symbol), amount * base / quote when
// it matches the quote symbol (result carries the base symbol); base wins if both match.
// status: 0 ok, 1 zero divisor, 2 quotient wider than AMOUNT_BITS, 3 no symbol match; the
// amount is zero on any error and the symbol is zero on a mismatch. One request is taken per
// cycle while req_stall is low; each result passes through the registers of the split 32x32
// partial product multiply (partial products, product sum, overflow check), then each of the
// AMOUNT_BITS restoring divide cells, then the output register. A stalled result backs up the
// chain only as far as its empty slots allow.

module asset_price_conversion #(
   parameter int AMOUNT_BITS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [AMOUNT_BITS-2:0]           req_asset_amount,
   input  logic [apc_pkg::SYMBOL_BITS-1:0]  req_asset_symbol,
   input  logic [AMOUNT_BITS-2:0]           req_base_amount,
   input  logic [apc_pkg::SYMBOL_BITS-1:0]  req_base_symbol,
   input  logic [AMOUNT_BITS-2:0]           req_quote_amount,
   input  logic [apc_pkg::SYMBOL_BITS-1:0]  req_quote_symbol,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [AMOUNT_BITS-1:0]           rsp_result_amount,
   output logic [apc_pkg::SYMBOL_BITS-1:0]  rsp_result_symbol,
   output logic [1:0]                       rsp_status
);

   localparam int IN_BITS = AMOUNT_BITS - 1;

   logic                    cell_valid [0:AMOUNT_BITS];
   logic                    cell_ready [0:AMOUNT_BITS];
   logic [IN_BITS-1:0]      cell_rem   [0:AMOUNT_BITS];
   logic [AMOUNT_BITS-1:0]  cell_work  [0:AMOUNT_BITS];
   logic [IN_BITS-1:0]      cell_div   [0:AMOUNT_BITS];
   apc_pkg::side_type       cell_side  [0:AMOUNT_BITS];

   logic                    mul_ready;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [AMOUNT_BITS-1:0]  amount_ff, amount_in;
   apc_pkg::side_type       side_ff;
   logic                    out_ready;

   assign req_stall = !mul_ready;

   apc_mul #(
      .AMOUNT_BITS (AMOUNT_BITS)
   ) u_mul (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_valid),
      .in_ready        (mul_ready),
      .in_asset_amount (req_asset_amount),
      .in_asset_symbol (req_asset_symbol),
      .in_base_amount  (req_base_amount),
      .in_base_symbol  (req_base_symbol),
      .in_quote_amount (req_quote_amount),
      .in_quote_symbol (req_quote_symbol),
      .out_valid       (cell_valid[0]),
      .out_ready       (cell_ready[0]),
      .out_rem         (cell_rem[0]),
      .out_work        (cell_work[0]),
      .out_divisor     (cell_div[0]),
      .out_side        (cell_side[0])
   );

   for (genvar i = 0; i < AMOUNT_BITS; i++) begin : g_cell
      apc_cell #(
         .AMOUNT_BITS (AMOUNT_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .in_valid    (cell_valid[i]),
         .in_ready    (cell_ready[i]),
         .in_rem      (cell_rem[i]),
         .in_work     (cell_work[i]),
         .in_divisor  (cell_div[i]),
         .in_side     (cell_side[i]),
         .out_valid   (cell_valid[i+1]),
         .out_ready   (cell_ready[i+1]),
         .out_rem     (cell_rem[i+1]),
         .out_work    (cell_work[i+1]),
         .out_divisor (cell_div[i+1]),
         .out_side    (cell_side[i+1])
      );
   end

   assign out_ready                = !rsp_valid_ff || !rsp_stall;
   assign cell_ready[AMOUNT_BITS]  = out_ready;

   always_comb begin
      amount_in    = (cell_side[AMOUNT_BITS].status == apc_pkg::STATUS_OK)
                   ? cell_work[AMOUNT_BITS] : '0;
      rsp_valid_in = out_ready ? cell_valid[AMOUNT_BITS] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cell_valid[AMOUNT_BITS] && out_ready) begin
         amount_ff <= amount_in;
         side_ff   <= cell_side[AMOUNT_BITS];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_amount = amount_ff;
   assign rsp_result_symbol = side_ff.symbol;
   assign rsp_status        = side_ff.status;

`ifndef SYNTHESIS
   a_error_zero_amount: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != apc_pkg::STATUS_OK) |-> (rsp_result_amount == '0))
      else $error("nonzero amount on an error status");

   a_mismatch_zero_symbol: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == apc_pkg::STATUS_MISMATCH) |-> (rsp_result_symbol == '0))
      else $error("symbol mismatch with nonzero symbol");

   a_empty_output_takes_request: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while output register is empty");
`endif

endmodule

/* dv/tb_asset_price_conversion.sv */
`timescale 1ns / 1ps

module tb_asset_price_conversion;

   localparam int AMOUNT_BITS    = 64;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef logic [AMOUNT_BITS-2:0] amount_in_type;
   typedef logic [apc_pkg::SYMBOL_BITS-1:0] symbol_type;

   typedef struct packed {
      amount_in_type asset_amount;
      symbol_type    asset_symbol;
      amount_in_type base_amount;
      symbol_type    base_symbol;
      amount_in_type quote_amount;
      symbol_type    quote_symbol;
   } price_request_type;

   typedef struct packed {
      logic [AMOUNT_BITS-1:0] amount;
      symbol_type             symbol;
      apc_pkg::status_type    status;
   } conversion_type;

   class conversion_board;
      conversion_type expected_q[$];
      int failures;
      int status_seen[4];

      function conversion_type predict_conversion(price_request_type r);
         conversion_type c;
         amount_in_type mult;
         amount_in_type divisor;
         logic [2*AMOUNT_BITS-1:0] product;
         logic [2*AMOUNT_BITS-1:0] quotient;
         c.amount = '0;
         c.symbol = '0;
         c.status = apc_pkg::STATUS_MISMATCH;
         // base side takes priority when both symbols match
         if (r.asset_symbol == r.base_symbol) begin
            mult = r.quote_amount;
            divisor = r.base_amount;
            c.symbol = r.quote_symbol;
         end else if (r.asset_symbol == r.quote_symbol) begin
            mult = r.base_amount;
            divisor = r.quote_amount;
            c.symbol = r.base_symbol;
         end else begin
            return c;
         end
         if (divisor == '0) begin
            c.status = apc_pkg::STATUS_ZERO_DIV;
            return c;
         end
         product = (2*AMOUNT_BITS)'(r.asset_amount) * (2*AMOUNT_BITS)'(mult);
         quotient = product / (2*AMOUNT_BITS)'(divisor);
         if ((quotient >> AMOUNT_BITS) != '0) begin
            c.status = apc_pkg::STATUS_OVERFLOW;
         end else begin
            c.status = apc_pkg::STATUS_OK;
            c.amount = quotient[AMOUNT_BITS-1:0];
         end
         return c;
      endfunction

      function void note_request(price_request_type r);
         conversion_type c;
         c = predict_conversion(r);
         status_seen[int'(c.status)]++;
         expected_q.push_back(c);
      endfunction

      function void check_result(logic [AMOUNT_BITS-1:0] amount, symbol_type symbol,
                                 logic [1:0] status);
         conversion_type c;
         if (expected_q.size() == 0) begin
            $error("result with nothing expected: amount %0h symbol %0h status %0d",
                   amount, symbol, status);
            failures++;
            return;
         end
         c = expected_q.pop_front();
         if (amount !== c.amount) begin
            $error("result_amount: expected %0h, got %0h", c.amount, amount);
            failures++;
         end
         if (symbol !== c.symbol) begin
            $error("result_symbol: expected %0h, got %0h", c.symbol, symbol);
            failures++;
         end
         if (status !== c.status) begin
            $error("status: expected %s, got %0d", c.status.name(), status);
            failures++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   amount_in_type req_asset_amount = '0;
   symbol_type    req_asset_symbol = '0;
   amount_in_type req_base_amount = '0;
   symbol_type    req_base_symbol = '0;
   amount_in_type req_quote_amount = '0;
   symbol_type    req_quote_symbol = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [AMOUNT_BITS-1:0] rsp_result_amount;
   symbol_type    rsp_result_symbol;
   logic [1:0]    rsp_status;

   conversion_board board = new();

   int idle_pct;
   int stall_pct;
   int hold_armed;
   int hold_seen;
   int hold_left;
   int quiet_cycles;

   asset_price_conversion #(
      .AMOUNT_BITS(AMOUNT_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_asset_amount(req_asset_amount),
      .req_asset_symbol(req_asset_symbol),
      .req_base_amount(req_base_amount),
      .req_base_symbol(req_base_symbol),
      .req_quote_amount(req_quote_amount),
      .req_quote_symbol(req_quote_symbol),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_amount(rsp_result_amount),
      .rsp_result_symbol(rsp_result_symbol),
      .rsp_status(rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: check, then pick the stall for the next cycle
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         board.check_result(rsp_result_amount, rsp_result_symbol, rsp_status);
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_armed != hold_seen) begin
         hold_seen = hold_armed;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   function automatic amount_in_type random_amount();
      logic [63:0] wide;
      int pick;
      wide = {$urandom, $urandom};
      pick = $urandom_range(9);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      if (pick == 2) return amount_in_type'(wide[15:0]);
      if (pick < 5) return amount_in_type'(wide) >> $urandom_range(AMOUNT_BITS-2);
      return amount_in_type'(wide);
   endfunction

   function automatic price_request_type random_request();
      price_request_type r;
      int pick;
      r.asset_amount = random_amount();
      r.base_amount = random_amount();
      r.quote_amount = random_amount();
      r.base_symbol = $urandom;
      r.quote_symbol = $urandom;
      pick = $urandom_range(19);
      if (pick < 9) begin
         r.asset_symbol = r.base_symbol;
      end else if (pick < 16) begin
         r.asset_symbol = r.quote_symbol;
      end else if (pick < 18) begin
         r.quote_symbol = r.base_symbol;
         r.asset_symbol = r.base_symbol;
      end else begin
         // one bit away from the base symbol, so the base side never matches
         r.asset_symbol = r.base_symbol
                        ^ (symbol_type'(1) << $urandom_range(apc_pkg::SYMBOL_BITS-1));
      end
      return r;
   endfunction

   function automatic price_request_type make_request(amount_in_type amt, symbol_type asym,
                                                      amount_in_type bamt, symbol_type bsym,
                                                      amount_in_type qamt, symbol_type qsym);
      price_request_type r;
      r.asset_amount = amt;
      r.asset_symbol = asym;
      r.base_amount = bamt;
      r.base_symbol = bsym;
      r.quote_amount = qamt;
      r.quote_symbol = qsym;
      return r;
   endfunction

   task automatic send_request(input price_request_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_asset_amount <= r.asset_amount;
      req_asset_symbol <= r.asset_symbol;
      req_base_amount <= r.base_amount;
      req_base_symbol <= r.base_symbol;
      req_quote_amount <= r.quote_amount;
      req_quote_symbol <= r.quote_symbol;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int count, input int send_idle, input int recv_stall);
      idle_pct = send_idle;
      stall_pct = recv_stall;
      repeat (count) send_request(random_request());
      wait_for_drain();
   endtask

   initial begin
      amount_in_type top;
      symbol_type sa;
      symbol_type sb;
      symbol_type sc;
      top = '1;
      sa = 32'h5553_4400;
      sb = 32'h4254_4300;
      sc = 32'h4554_4800;
      idle_pct = 0;
      stall_pct = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(make_request('0, '0, '0, '0, '0, '0));
      send_request(make_request(top, sa, top, sa, top, sb));
      send_request(make_request(top, sa, amount_in_type'(1), sa, top, sb));
      send_request(make_request(top, sa, amount_in_type'(1), sa, amount_in_type'(2), sb));
      send_request(make_request(top, sa, amount_in_type'(1), sa, amount_in_type'(3), sb));
      send_request(make_request(amount_in_type'(7), sa, amount_in_type'(2), sa,
                                amount_in_type'(1), sb));
      send_request(make_request('0, sa, amount_in_type'(5), sa, top, sb));
      send_request(make_request(amount_in_type'(100), sa, '0, sa, amount_in_type'(9), sb));
      send_request(make_request(amount_in_type'(100), sb, amount_in_type'(9), sa,
                                amount_in_type'(3), sb));
      send_request(make_request(amount_in_type'(100), sb, amount_in_type'(9), sa, '0, sb));
      send_request(make_request(top, sb, top, sa, amount_in_type'(1), sb));
      send_request(make_request(top, sb, top, sa, top, sb));
      send_request(make_request(amount_in_type'(10), sa, amount_in_type'(5), sa,
                                amount_in_type'(20), sa));
      send_request(make_request(amount_in_type'(10), sa, '0, sa, amount_in_type'(20), sa));
      send_request(make_request(top, sc, top, sa, top, sb));
      send_request(make_request(top, 32'hFFFF_FFFF, amount_in_type'(3), 32'hFFFF_FFFE,
                                amount_in_type'(5), 32'h7FFF_FFFF));
      send_request(make_request(top, 32'hFFFF_FFFF, amount_in_type'(1), 32'hFFFF_FFFF,
                                amount_in_type'(1), '0));
      send_request(make_request(amount_in_type'(1), sa, top, sa, amount_in_type'(1), sb));
      send_request(make_request(top, sa, top, sa, '0, sb));
      send_request(make_request(top, sa, amount_in_type'(2), sa, top, sb));
      // pause until every directed request has come back
      wait_for_drain();

      run_phase(150, 0, 0);
      run_phase(120, 56, 0);
      run_phase(120, 0, 56);
      run_phase(120, 35, 35);
      // long result hold-off while requests keep coming, so the chain fills up
      hold_armed++;
      run_phase(120, 0, 0);

      repeat (AMOUNT_BITS + 8) @(posedge clock);
      $display("covered %0d conversions: %0d ok, %0d zero divisor, %0d overflow, %0d mismatch",
               board.status_seen[0] + board.status_seen[1] + board.status_seen[2] +
               board.status_seen[3], board.status_seen[0], board.status_seen[1],
               board.status_seen[2], board.status_seen[3]);
      $display("phases: back to back, sender gaps, result stalls, both, and a long hold-off");
      if (board.failures == 0 && board.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
